// ----- hdl/pirt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pirt_pkg;

   // Table dimensions.
   localparam int unsigned NUM_BUSES   = 8;
   localparam int unsigned NUM_DEVICES = 32;
   localparam int unsigned NUM_PINS    = 4;
   localparam int unsigned MAX_HOPS    = 8;

   // Field widths of the transfer payloads.
   localparam int unsigned KIND_W = 2;
   localparam int unsigned BUS_W  = 3;
   localparam int unsigned DEV_W  = 5;
   localparam int unsigned PIN_W  = 3;
   localparam int unsigned IRQ_W  = 8;

   localparam int unsigned STORE_DEPTH = NUM_BUSES * NUM_DEVICES * NUM_PINS;
   localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
   localparam int unsigned PIN_IDX_W   = $clog2(NUM_PINS);
   localparam int unsigned HOP_W       = $clog2(MAX_HOPS + 1);

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BUS_W-1:0]  bus;
      logic [BUS_W-1:0]  parent_bus;
      logic [DEV_W-1:0]  device;
      logic [PIN_W-1:0]  pin;
      logic [IRQ_W-1:0]  route_irq;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [IRQ_W-1:0] irq_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_WALK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic load_item;
      logic decode;
      logic walk;
      logic load_rsp;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic need_walk;
      logic walk_done;
      logic rsp_free;
   } dp_status_type;

   // Flat index of one irq store entry.
   function automatic logic [STORE_AW-1:0] slot_of(
      input logic [BUS_W-1:0]     b,
      input logic [DEV_W-1:0]     d,
      input logic [PIN_IDX_W-1:0] p
   );
      return STORE_AW'((32'(b) * NUM_DEVICES + 32'(d)) * NUM_PINS + 32'(p));
   endfunction

endpackage

`default_nettype wire

// ----- hdl/pci_irq_route_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// PCI interrupt routing table with bridge swizzle lookup.
// Items arrive on the req_ channel (valid/ready); each gives exactly one
// transfer on the rsp_ channel, in order. Kinds: register a bus with its
// parent and bridge device, add an irq for (bus, device, pin), or look up
// the irq of (bus, device, pin), climbing through parent buses while the
// entry read is zero.
// Register and add items pass through DECODE and DONE; a valid lookup also
// passes through WALK, which climbs h buses with h at most MAX_HOPS. One
// item is worked on at a time, and the block returns to idle for the next
// one in the cycle after the response is loaded. The walk reads the irq
// store once per hop through its single read port, which sets the length
// of a lookup.
// After reset the irq store is swept to zero, one entry a cycle, across all
// 1024 entries; req_ready stays low until the sweep ends. The bus table and
// the output valid flag are cleared at once.
// The response sits in an output register; a new request is accepted while
// it waits. If the receiver still holds off rsp_ready when the next result
// is ready, the block waits with that result and takes no further request.

module pci_irq_route_table (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  pirt_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output pirt_pkg::rsp_type   rsp_data
);

   pirt_pkg::ctl_cmd_type   cmd;
   pirt_pkg::dp_status_type status;

   pirt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pirt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ----- hdl/pirt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pirt_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  pirt_pkg::dp_status_type  status,
   output pirt_pkg::ctl_cmd_type    cmd
);

   pirt_pkg::state_type state_ff;
   pirt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pirt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pirt_pkg::ST_CLEAR: begin
            if (status.clear_done) state_in = pirt_pkg::ST_IDLE;
         end
         pirt_pkg::ST_IDLE: begin
            if (req_valid) state_in = pirt_pkg::ST_DECODE;
         end
         pirt_pkg::ST_DECODE: begin
            state_in = status.need_walk ? pirt_pkg::ST_WALK : pirt_pkg::ST_DONE;
         end
         pirt_pkg::ST_WALK: begin
            if (status.walk_done) state_in = pirt_pkg::ST_DONE;
         end
         pirt_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = pirt_pkg::ST_IDLE;
         end
         default: begin
            state_in = pirt_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pirt_pkg::ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         pirt_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         pirt_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
         end
         pirt_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         pirt_pkg::ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/pirt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pirt_dp (
   input  wire                      clock,
   input  wire                      reset,
   input  pirt_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output pirt_pkg::rsp_type        rsp_data,
   input  pirt_pkg::ctl_cmd_type    cmd,
   output pirt_pkg::dp_status_type  status
);

   // Bus table: present bits, parent bus and bridge device per bus.
   logic [pirt_pkg::NUM_BUSES-1:0] present_ff;
   logic [pirt_pkg::BUS_W-1:0]     parent_ff [pirt_pkg::NUM_BUSES];
   logic [pirt_pkg::DEV_W-1:0]     bridge_ff [pirt_pkg::NUM_BUSES];

   // Irq store, cleared by a sweep after reset.
   logic [pirt_pkg::IRQ_W-1:0]    irq_mem [pirt_pkg::STORE_DEPTH];
   logic [pirt_pkg::IRQ_W-1:0]    rd_data_ff;
   logic [pirt_pkg::STORE_AW-1:0] rd_addr;
   logic [pirt_pkg::STORE_AW-1:0] wr_addr;
   logic [pirt_pkg::IRQ_W-1:0]    wr_data;
   logic                          wr_en;
   logic [pirt_pkg::STORE_AW-1:0] clr_cnt_ff;

   pirt_pkg::req_type item_ff;

   // Walk registers.
   logic [pirt_pkg::BUS_W-1:0]     cur_bus_ff;
   logic [pirt_pkg::PIN_IDX_W-1:0] offset_ff;
   logic [pirt_pkg::HOP_W-1:0]     hops_ff;

   // Result being built and the output register.
   logic                       res_ok_ff;
   logic [pirt_pkg::IRQ_W-1:0] res_irq_ff;
   logic                       rsp_valid_ff;
   pirt_pkg::rsp_type          rsp_ff;

   logic                           reg_ok;
   logic                           route_ok;
   logic [pirt_pkg::PIN_IDX_W-1:0] item_pidx;
   logic [pirt_pkg::PIN_IDX_W-1:0] item_offset;
   logic [pirt_pkg::STORE_AW-1:0]  item_slot;
   logic [pirt_pkg::BUS_W-1:0]     up_bus;
   logic [pirt_pkg::PIN_IDX_W-1:0] next_offset;
   logic                           hit;
   logic                           stop;

   // Item checks.
   always_comb begin
      reg_ok = (32'(item_ff.bus) < pirt_pkg::NUM_BUSES) &&
               (32'(item_ff.parent_bus) < pirt_pkg::NUM_BUSES) &&
               (32'(item_ff.device) < pirt_pkg::NUM_DEVICES);
      route_ok = (32'(item_ff.pin) >= 32'd1) &&
                 (32'(item_ff.pin) <= pirt_pkg::NUM_PINS) &&
                 (32'(item_ff.bus) < pirt_pkg::NUM_BUSES) &&
                 (32'(item_ff.device) < pirt_pkg::NUM_DEVICES) &&
                 present_ff[item_ff.bus];
      item_pidx   = pirt_pkg::PIN_IDX_W'(32'(item_ff.pin) - 32'd1);
      item_offset = pirt_pkg::PIN_IDX_W'(
                       (32'(item_ff.device) + 32'(item_pidx)) % pirt_pkg::NUM_PINS);
      item_slot   = pirt_pkg::slot_of(item_ff.bus, item_ff.device, item_pidx);
   end

   // One hop of the walk: evaluate the entry just read, prepare the next read.
   always_comb begin
      up_bus      = parent_ff[cur_bus_ff];
      next_offset = pirt_pkg::PIN_IDX_W'(
                       (32'(offset_ff) + 32'(bridge_ff[cur_bus_ff])) % pirt_pkg::NUM_PINS);
      hit  = (rd_data_ff != '0);
      stop = (32'(hops_ff) >= pirt_pkg::MAX_HOPS) ||
             (up_bus == cur_bus_ff) ||
             (32'(up_bus) >= pirt_pkg::NUM_BUSES) ||
             !present_ff[up_bus];
   end

   always_comb begin
      rd_addr = cmd.decode ? item_slot
                           : pirt_pkg::slot_of(up_bus, '0, next_offset);
      wr_en   = cmd.clear_en ||
                (cmd.decode && (item_ff.kind == pirt_pkg::KIND_ADD) && route_ok);
      wr_addr = cmd.clear_en ? clr_cnt_ff : item_slot;
      wr_data = cmd.clear_en ? '0 : item_ff.route_irq;
   end

   always_ff @(posedge clock) begin
      if (wr_en) irq_mem[wr_addr] <= wr_data;
      rd_data_ff <= irq_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         for (int i = 0; i < pirt_pkg::NUM_BUSES; i++) begin
            parent_ff[i] <= '0;
            bridge_ff[i] <= '0;
         end
      end else if (cmd.decode && (item_ff.kind == pirt_pkg::KIND_REGISTER) && reg_ok) begin
         present_ff[item_ff.bus] <= 1'b1;
         parent_ff[item_ff.bus]  <= item_ff.parent_bus;
         bridge_ff[item_ff.bus]  <= item_ff.device;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         cur_bus_ff <= item_ff.bus;
         offset_ff  <= item_offset;
         hops_ff    <= '0;
         res_irq_ff <= '0;
         case (item_ff.kind)
            pirt_pkg::KIND_REGISTER: res_ok_ff <= reg_ok;
            pirt_pkg::KIND_ADD:      res_ok_ff <= route_ok;
            pirt_pkg::KIND_LOOKUP:   res_ok_ff <= route_ok;
            default:                 res_ok_ff <= 1'b0;
         endcase
      end else if (cmd.walk) begin
         if (hit) begin
            res_irq_ff <= rd_data_ff;
         end else if (!stop) begin
            cur_bus_ff <= up_bus;
            offset_ff  <= next_offset;
            hops_ff    <= hops_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.ok      <= res_ok_ff;
         rsp_ff.irq_out <= res_irq_ff;
      end
   end

   always_comb begin
      status.clear_done = (clr_cnt_ff == pirt_pkg::STORE_AW'(pirt_pkg::STORE_DEPTH - 1));
      status.need_walk  = (item_ff.kind == pirt_pkg::KIND_LOOKUP) && route_ok;
      status.walk_done  = hit || stop;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/pirt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pirt_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input pirt_pkg::rsp_type rsp_data
);

   // A held response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset leaves the block busy with the sweep and with no response.
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not quiet after reset");

   // One item at a time: after a request transfer the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // A new response comes with the block free for the next request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response loaded without returning to idle");

   // A failed item never reports an irq.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.irq_out == '0)
      else $error("irq reported with ok low");

endmodule

bind pci_irq_route_table pirt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/pci_irq_route_table_checker.sv -----
`timescale 1ns / 1ps

module pci_irq_route_table_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  pirt_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  pirt_pkg::rsp_type  rsp_data,
   output int unsigned        fail_count,
   output int unsigned        results_owed
);

   import pirt_pkg::*;

   // Shadow copy of the routing state.
   logic              bus_known     [NUM_BUSES];
   logic [BUS_W-1:0]  parent_bus_of [NUM_BUSES];
   logic [DEV_W-1:0]  bridge_of     [NUM_BUSES];
   logic [IRQ_W-1:0]  irq_table     [STORE_DEPTH];

   // Results still owed by the block, oldest first.
   rsp_type           owed_q [$];

   function automatic int table_index(input int b, input int d, input int p);
      return (b * NUM_DEVICES + d) * NUM_PINS + p;
   endfunction

   // Walk toward the root while the entry read is zero, swizzling the pin
   // by each bridge device on the way up.
   function automatic int resolve_irq(input int b, input int d, input int p);
      int irq;
      int offset;
      int hops;
      int up;
      irq    = int'(irq_table[table_index(b, d, p)]);
      offset = d + p;
      hops   = 0;
      while (irq == 0) begin
         if (hops >= MAX_HOPS) return 0;
         up = int'(parent_bus_of[b]);
         if (up == b || up >= NUM_BUSES) return 0;
         offset += int'(bridge_of[b]);
         b = up;
         if (!bus_known[b]) return 0;
         irq = int'(irq_table[table_index(b, 0, offset % NUM_PINS)]);
         hops++;
      end
      return irq;
   endfunction

   // Applies one item to the shadow state and gives the result it causes.
   function automatic rsp_type route_outcome(input req_type it);
      rsp_type r;
      int      pidx;
      logic    args_ok;
      r = '0;
      case (it.kind)
         KIND_REGISTER: begin
            if (it.bus < NUM_BUSES && it.parent_bus < NUM_BUSES &&
                it.device < NUM_DEVICES) begin
               bus_known[it.bus]     = 1'b1;
               parent_bus_of[it.bus] = it.parent_bus;
               bridge_of[it.bus]     = it.device;
               r.ok                  = 1'b1;
            end
         end
         KIND_ADD, KIND_LOOKUP: begin
            args_ok = it.pin >= 1 && it.pin <= NUM_PINS &&
                      it.bus < NUM_BUSES && it.device < NUM_DEVICES;
            if (args_ok && bus_known[it.bus]) begin
               pidx = int'(it.pin) - 1;
               r.ok = 1'b1;
               if (it.kind == KIND_ADD)
                  irq_table[table_index(int'(it.bus), int'(it.device), pidx)] =
                     it.route_irq;
               else
                  r.irq_out = IRQ_W'(resolve_irq(int'(it.bus), int'(it.device), pidx));
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ns  ERROR  %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (bus_known[i]) begin
            bus_known[i]     = 1'b0;
            parent_bus_of[i] = '0;
            bridge_of[i]     = '0;
         end
         foreach (irq_table[i]) irq_table[i] = '0;
         owed_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               report_error($sformatf("result with none owed: ok=%0b irq_out=%0d",
                                      rsp_data.ok, rsp_data.irq_out));
            end else begin
               want = owed_q.pop_front();
               if (rsp_data.ok !== want.ok)
                  report_error($sformatf("ok is %0b, expected %0b",
                                         rsp_data.ok, want.ok));
               if (rsp_data.irq_out !== want.irq_out)
                  report_error($sformatf("irq_out is %0d, expected %0d",
                                         rsp_data.irq_out, want.irq_out));
            end
         end
         if (req_valid && req_ready) owed_q = {owed_q, route_outcome(req_data)};
      end
      results_owed = owed_q.size();
   end

endmodule

// ----- tb/pci_irq_route_table_tb.sv -----
`timescale 1ns / 1ps

// Top of the routing table testbench. It makes the stimulus, drives the
// receiver's stall pattern and gives the verdict; the checker instance
// beside the block predicts and compares every transfer.

module pci_irq_route_table_tb;

   import pirt_pkg::*;

   localparam int unsigned HALF_PERIOD  = 6;
   localparam int unsigned RANDOM_ITEMS = 1250;
   // The worst case per item is roughly the longest lookup, the longest sender
   // gap and the longest receiver stall, plus the store sweep after reset. The
   // limit leaves several times that.
   localparam int unsigned CYCLE_LIMIT  = 400000;
   // Cycles allowed after the last result, well above the longest lookup.
   localparam int unsigned SETTLE_CYCLES = 24;

   // The one kind value the block does not define.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum int {RX_OPEN, RX_JITTER, RX_LONG_STALL} rx_mode_type;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   req_type      req_data  = '0;
   logic         rsp_ready = 1'b0;
   wire          req_ready;
   wire          rsp_valid;
   rsp_type      rsp_data;

   int unsigned  fail_count;
   int unsigned  results_owed;
   int unsigned  cycle_count = 0;

   // Sender burst bookkeeping.
   int           burst_left = 0;

   // Receiver stall pattern state.
   rx_mode_type  rx_mode      = RX_OPEN;
   int           rx_mode_left = 0;
   int           rx_hold_left = 0;
   logic         rx_hold_high = 1'b0;

   pci_irq_route_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pci_irq_route_table_checker route_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // The run is cut off if it hangs; a hang always counts as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still owed",
                  cycle_count, results_owed);
         $display("Regression FAIL");
         $finish;
      end
   end

   // The receiver switches at random between three moods: always
   // ready, ready about two thirds of the time, and long stalls broken by
   // short ready windows. The long stalls make the block hold a finished
   // result and refuse the next request, which is the back pressure path.
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = 256;
      end
      rx_mode_left--;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_JITTER: rsp_ready <= ($urandom_range(0, 2) != 0);
         default: begin
            if (rx_hold_left == 0) begin
               rx_hold_high = !rx_hold_high;
               rx_hold_left = rx_hold_high ? $urandom_range(1, 4)
                                           : $urandom_range(1, 20);
            end
            rx_hold_left--;
            rsp_ready <= rx_hold_high;
         end
      endcase
   end

   function automatic req_type make_item(input logic [KIND_W-1:0] kind,
                                         input int b, input int pb,
                                         input int d, input int pin,
                                         input int irq);
      req_type it;
      it.kind       = kind;
      it.bus        = BUS_W'(b);
      it.parent_bus = BUS_W'(pb);
      it.device     = DEV_W'(d);
      it.pin        = PIN_W'(pin);
      it.route_irq  = IRQ_W'(irq);
      return it;
   endfunction

   // Most random items are well formed so that buses get registered, routes
   // land in row 0 of upstream buses and lookups really climb. Parents are
   // mostly lower bus numbers, giving trees rooted at bus 0, with a share of
   // self parents and loops. A few items carry a bad pin or the unused kind.
   function automatic req_type random_item();
      req_type it;
      int      roll;
      int      b;
      b             = $urandom_range(0, NUM_BUSES - 1);
      it.kind       = KIND_LOOKUP;
      it.bus        = BUS_W'(b);
      it.parent_bus = BUS_W'($urandom_range(0, NUM_BUSES - 1));
      it.device     = DEV_W'($urandom_range(0, NUM_DEVICES - 1));
      it.pin        = PIN_W'($urandom_range(1, NUM_PINS));
      it.route_irq  = IRQ_W'($urandom_range(0, 255));
      roll          = $urandom_range(0, 99);
      if (roll < 12) begin
         it.kind = KIND_REGISTER;
         if (b > 0 && $urandom_range(0, 99) < 65)
            it.parent_bus = BUS_W'($urandom_range(0, b - 1));
         else if ($urandom_range(0, 1) == 0)
            it.parent_bus = BUS_W'(b);
      end else if (roll < 45) begin
         it.kind = KIND_ADD;
         if ($urandom_range(0, 1) == 0) it.device = '0;
         if ($urandom_range(0, 9) == 0) it.route_irq = '0;
      end else if (roll < 93) begin
         it.kind = KIND_LOOKUP;
         if ($urandom_range(0, 1) == 0) it.device = DEV_W'($urandom_range(0, 3));
      end else if (roll < 97) begin
         it.kind = ($urandom_range(0, 1) == 0) ? KIND_ADD : KIND_LOOKUP;
         it.pin  = ($urandom_range(0, 1) == 0) ? '0
                                               : PIN_W'($urandom_range(NUM_PINS + 1, 7));
      end else begin
         it.kind = KIND_UNUSED;
         it.pin  = PIN_W'($urandom_range(0, 7));
      end
      return it;
   endfunction

   // Offers one item and returns at the edge where the transfer happens.
   // Items go out in bursts; between bursts valid drops for a random gap,
   // and about a quarter of the bursts follow the last one with no gap.
   // Inside a burst valid stays high and only the payload changes.
   task automatic send_item(input req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drops valid and waits for every owed result to come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      burst_left = 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Add and look up on a bus that is not registered yet,
      // then the unused kind with every field at its maximum.
      send_item(make_item(KIND_LOOKUP, 3, 0, 0, 1, 0));
      send_item(make_item(KIND_ADD, 5, 0, 31, 4, 255));
      send_item(make_item(KIND_UNUSED, 7, 7, 31, 7, 255));

      // Topology: bus 0 is a root that is its own parent, 1 hangs off 0,
      // 2 hangs off 1 through bridge device 31, and bus 7 points at bus 6,
      // which is never registered here.
      send_item(make_item(KIND_REGISTER, 0, 0, 0, 0, 0));
      send_item(make_item(KIND_REGISTER, 1, 0, 2, 0, 0));
      send_item(make_item(KIND_REGISTER, 2, 1, 31, 0, 0));
      send_item(make_item(KIND_REGISTER, 7, 6, 31, 7, 255));

      // Fill row 0 of the root on every pin, irq extremes included, and add one entry on bus 2 at device 31.
      send_item(make_item(KIND_ADD, 0, 0, 0, 1, 1));
      send_item(make_item(KIND_ADD, 0, 0, 0, 2, 128));
      send_item(make_item(KIND_ADD, 0, 0, 0, 3, 255));
      send_item(make_item(KIND_ADD, 0, 0, 0, 4, 77));
      send_item(make_item(KIND_ADD, 2, 7, 31, 4, 255));

      // A direct hit, a two level climb with swizzle, a self parented root
      // with nothing stored, and a climb into an absent parent.
      send_item(make_item(KIND_LOOKUP, 2, 0, 31, 4, 0));
      send_item(make_item(KIND_LOOKUP, 2, 0, 5, 2, 0));
      send_item(make_item(KIND_LOOKUP, 0, 0, 9, 3, 0));
      send_item(make_item(KIND_LOOKUP, 7, 0, 1, 1, 0));

      // Pins zero and above the pin count are refused.
      send_item(make_item(KIND_ADD, 1, 0, 3, 0, 9));
      send_item(make_item(KIND_LOOKUP, 1, 0, 3, 5, 0));

      // Buses 3 and 4 point at each other, so the climb runs into the
      // hop limit.
      send_item(make_item(KIND_REGISTER, 3, 4, 1, 0, 0));
      send_item(make_item(KIND_REGISTER, 4, 3, 6, 0, 0));
      send_item(make_item(KIND_LOOKUP, 3, 0, 2, 1, 0));

      // Registering bus 2 again keeps its routes; then an irq of zero
      // unroutes the entry, and the now self parented bus gives zero.
      send_item(make_item(KIND_REGISTER, 2, 2, 0, 0, 0));
      send_item(make_item(KIND_LOOKUP, 2, 0, 31, 4, 0));
      send_item(make_item(KIND_ADD, 2, 0, 31, 4, 0));
      send_item(make_item(KIND_LOOKUP, 2, 0, 31, 4, 0));

      // Let the block run dry once before the random part starts.
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_item(random_item());
         if (n == RANDOM_ITEMS / 2) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
